@@ rtl/core/nps_pkg.sv @@
// shared types and constants for the nearest palette color search block
// no dependencies; imported by every module under rtl/core
`default_nettype none

package nps_pkg;

  // palette geometry
  localparam int PALETTE_ENTRIES = 256;
  localparam int ADDR_W          = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(PALETTE_ENTRIES - 1);

  // field widths fixed by the interface
  localparam int IDX_W   = 8;
  localparam int CH_W    = 8;
  localparam int RGB_W   = 3 * CH_W;
  localparam int WORD_W  = 32;
  localparam int COLOR_W = 15;

  // distance arithmetic: channel difference squared, three squares summed
  localparam int SQ_W   = 2 * CH_W;
  localparam int DIST_W = SQ_W + 2;

  // request kinds
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // alpha handling of the packed table word
  localparam logic [CH_W-1:0]  ALPHA_OPAQUE      = 8'hFF;
  localparam logic [CH_W-1:0]  ALPHA_CLEAR       = 8'h00;
  localparam logic [IDX_W-1:0] TRANSPARENT_INDEX = 8'hFF;

  // a 5-bit channel widens to 8 bits with this value in the low three bits
  localparam logic [2:0] CH_OFFSET = 3'd4;

  // tag that travels with each palette read through the scan pipeline
  typedef struct packed {
    logic              valid;
    logic              last;
    logic [ADDR_W-1:0] idx;
  } scan_tag_t;

endpackage

`default_nettype wire

@@ rtl/core/nps_palette_ram.sv @@
// palette storage: one write port, one read port with registered read data
// depends on nps_pkg
`default_nettype none

module nps_palette_ram
  import nps_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [RGB_W-1:0]  wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output      logic [RGB_W-1:0]  rd_data
);

  logic [RGB_W-1:0] mem [PALETTE_ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/nps_dist_stage.sv @@
// per-channel absolute difference and square of one palette entry, registered
// depends on nps_pkg
`default_nettype none

module nps_dist_stage
  import nps_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire scan_tag_t        in_tag,
  input  wire logic [RGB_W-1:0] entry,
  input  wire logic [CH_W-1:0]  q_red,
  input  wire logic [CH_W-1:0]  q_green,
  input  wire logic [CH_W-1:0]  q_blue,
  output      scan_tag_t        out_tag,
  output      logic [SQ_W-1:0]  sq_red,
  output      logic [SQ_W-1:0]  sq_green,
  output      logic [SQ_W-1:0]  sq_blue
);

  logic [CH_W-1:0] e_red, e_green, e_blue;
  logic [CH_W-1:0] d_red, d_green, d_blue;

  assign e_red   = entry[CH_W-1:0];
  assign e_green = entry[2*CH_W-1:CH_W];
  assign e_blue  = entry[3*CH_W-1:2*CH_W];

  assign d_red   = (q_red   >= e_red)   ? (q_red   - e_red)   : (e_red   - q_red);
  assign d_green = (q_green >= e_green) ? (q_green - e_green) : (e_green - q_green);
  assign d_blue  = (q_blue  >= e_blue)  ? (q_blue  - e_blue)  : (e_blue  - q_blue);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_tag <= '0;
    end else begin
      out_tag <= in_tag;
    end
  end

  always_ff @(posedge clk) begin
    sq_red   <= SQ_W'(d_red)   * SQ_W'(d_red);
    sq_green <= SQ_W'(d_green) * SQ_W'(d_green);
    sq_blue  <= SQ_W'(d_blue)  * SQ_W'(d_blue);
  end

endmodule

`default_nettype wire

@@ rtl/core/nearest_palette_color_search.sv @@
// top level of the nearest palette color search: control, scan and best-match tracking
// depends on nps_pkg, nps_palette_ram and nps_dist_stage
//
// usage:
//   an item is transferred at a rising edge where start is high and busy is low.
//   req_type selects a load (palette write) or a query (nearest color search).
//   every item gives exactly one result, shown for one cycle with done high;
//   the receiver cannot stall, so the result is gone after that cycle.
// load:
//   red/green/blue are written to entry_index at the transfer edge; done rises
//   the next cycle with the packed table word (alpha, blue, green, red) and
//   best_index zero. busy stays low, so loads can follow each other every cycle.
// query:
//   color15 is widened per channel and every palette entry is read, one per
//   cycle, from the single palette memory port. a two-stage pipeline behind the
//   read squares the channel differences and keeps the running minimum (strict
//   less-than, so the lowest index wins a tie). done rises with best_index and
//   table_word zero once the last entry has left the pipeline; busy drops in
//   that cycle, so the next item can be presented while done is high.
// reset:
//   rst clears control state only; palette contents are undefined until loaded,
//   and queries are meant to follow a full palette load.
`default_nettype none

module nearest_palette_color_search
  import nps_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output      logic               busy,
  input  wire logic               req_type,
  input  wire logic [IDX_W-1:0]   entry_index,
  input  wire logic [CH_W-1:0]    red,
  input  wire logic [CH_W-1:0]    green,
  input  wire logic [CH_W-1:0]    blue,
  input  wire logic [COLOR_W-1:0] color15,
  output      logic               done,
  output      logic [WORD_W-1:0]  table_word,
  output      logic [IDX_W-1:0]   best_index
);

  // control states
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0]        state;
  logic [ADDR_W-1:0] scan_cnt;

  // query color, widened to 8 bits per channel
  logic [CH_W-1:0] q_red, q_green, q_blue;

  // transfer decode
  logic accept, accept_load, accept_query, in_range, wr_en;

  // read issue and pipeline tags
  logic             rd_en;
  scan_tag_t        rd_tag;
  scan_tag_t        sq_tag;
  logic [RGB_W-1:0] rd_data;
  logic [SQ_W-1:0]  sq_red, sq_green, sq_blue;

  // running minimum
  logic [DIST_W-1:0] sum_sq;
  logic [DIST_W-1:0] best_dist;
  logic [ADDR_W-1:0] best_idx;
  logic              take;
  logic [ADDR_W-1:0] final_idx;

  // packed table word of a load
  logic [CH_W-1:0]   alpha;
  logic [WORD_W-1:0] load_word;

  assign busy         = (state != ST_IDLE);
  assign accept       = start && !busy;
  assign accept_load  = accept && (req_type == REQ_LOAD);
  assign accept_query = accept && (req_type == REQ_QUERY);

  // loads beyond the palette size are reported but not stored
  assign in_range = ((IDX_W+1)'(entry_index) < (IDX_W+1)'(PALETTE_ENTRIES));
  assign wr_en    = accept_load && in_range;

  assign alpha     = (entry_index == TRANSPARENT_INDEX) ? ALPHA_CLEAR : ALPHA_OPAQUE;
  assign load_word = {alpha, blue, green, red};

  // one palette read per cycle while scanning
  assign rd_en = (state == ST_SCAN);

  nps_palette_ram u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (entry_index[ADDR_W-1:0]),
    .wr_data ({blue, green, red}),
    .rd_en   (rd_en),
    .rd_addr (scan_cnt),
    .rd_data (rd_data)
  );

  nps_dist_stage u_dist (
    .clk      (clk),
    .rst      (rst),
    .in_tag   (rd_tag),
    .entry    (rd_data),
    .q_red    (q_red),
    .q_green  (q_green),
    .q_blue   (q_blue),
    .out_tag  (sq_tag),
    .sq_red   (sq_red),
    .sq_green (sq_green),
    .sq_blue  (sq_blue)
  );

  // sum of squares and compare; the first entry always becomes the candidate
  assign sum_sq    = DIST_W'(sq_red) + DIST_W'(sq_green) + DIST_W'(sq_blue);
  assign take      = sq_tag.valid && ((sq_tag.idx == '0) || (sum_sq < best_dist));
  assign final_idx = take ? sq_tag.idx : best_idx;

  // query color capture
  always_ff @(posedge clk) begin
    if (accept_query) begin
      q_red   <= {color15[4:0],   CH_OFFSET};
      q_green <= {color15[9:5],   CH_OFFSET};
      q_blue  <= {color15[14:10], CH_OFFSET};
    end
  end

  // running minimum payload
  always_ff @(posedge clk) begin
    if (take) begin
      best_dist <= sum_sq;
      best_idx  <= sq_tag.idx;
    end
  end

  // control, read tags and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      scan_cnt <= '0;
      rd_tag   <= '0;
      done     <= 1'b0;
    end else begin
      // tag follows the read into the registered memory output
      rd_tag.valid <= rd_en;
      rd_tag.last  <= rd_en && (scan_cnt == LAST_ADDR);
      rd_tag.idx   <= scan_cnt;

      case (state)
        ST_IDLE: begin
          if (accept_query) begin
            state    <= ST_SCAN;
            scan_cnt <= '0;
          end
        end
        ST_SCAN: begin
          scan_cnt <= scan_cnt + 1'b1;
          if (scan_cnt == LAST_ADDR) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (sq_tag.valid && sq_tag.last) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase

      // one result per transfer, shown for exactly one cycle
      done <= accept_load || (sq_tag.valid && sq_tag.last);
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept_load) begin
      table_word <= load_word;
      best_index <= '0;
    end else if (sq_tag.valid && sq_tag.last) begin
      table_word <= '0;
      best_index <= IDX_W'(final_idx);
    end
  end

  // a result never appears while a query is still scanning
  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  // an accepted query occupies the block in the next cycle
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy && req_type == REQ_QUERY) |=> busy)
    else $error("query transfer did not start a scan");

  // an accepted load gives its result in the next cycle with a zero index
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy && req_type == REQ_LOAD) |=> (done && best_index == '0))
    else $error("load result missing or malformed");

  // the scan pipeline only carries reads while a query is active
  assert property (@(posedge clk) disable iff (rst) sq_tag.valid |-> busy)
    else $error("scan pipeline active while idle");

endmodule

`default_nettype wire
